// ===== rtl/setsu_pkg.sv =====
// Shared constants and operation codes of the sparse eligibility trace store.
package setsu_pkg;

    localparam int NUM_TRACES = 1024;
    localparam int MAX_ACTIVE = 256;

    localparam int IDX_W = 10;
    localparam int POS_W = 8;
    localparam int CNT_W = 9;
    localparam int VAL_W = 16;
    localparam int OP_W  = 3;

    localparam logic [VAL_W-1:0] THR_RESET = 16'd164;

    // floor(x / 10) for a 16-bit x is (x * 0xCCCD) >> 19.
    localparam logic [VAL_W-1:0] RECIP_TEN   = 16'hCCCD;
    localparam int               RECIP_SHIFT = 19;

    localparam logic [OP_W-1:0] OP_SET        = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
    localparam logic [OP_W-1:0] OP_DECAY      = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_TRACE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_ENTRY = 3'd4;

endpackage

// ===== rtl/setsu_ifs.sv =====
// Request and response channel interfaces of the trace store.
interface setsu_req_if import setsu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] trace_index;
    logic [VAL_W-1:0] trace_value;
    logic [VAL_W-1:0] decay_rate;

    modport source (output valid, operation, trace_index, trace_value, decay_rate,
                    input ready);
    modport sink   (input valid, operation, trace_index, trace_value, decay_rate,
                    output ready);
endinterface

interface setsu_rsp_if import setsu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] trace_out;
    logic [IDX_W-1:0] entry_out;
    logic [CNT_W-1:0] active_count;
    logic [VAL_W-1:0] threshold_out;

    modport source (output valid, trace_out, entry_out, active_count, threshold_out,
                    input ready);
    modport sink   (input valid, trace_out, entry_out, active_count, threshold_out,
                    output ready);
endinterface

// ===== rtl/setsu_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module setsu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/sparse_eligibility_trace_store_unit.sv =====
// Top level of the sparse eligibility trace store: sequencer, memories and output register.
//
// This block holds 1024 unsigned Q2.14 trace values, a compact list of up to
// 256 active entries and a map from each entry to its list position, all in
// single-port-write, registered-read RAMs. One transaction is processed at a
// time by a sequencer that reads, modifies and writes back those memories.
// After reset the trace RAM is swept to zero, one entry per cycle, and no
// request is taken until the sweep ends; configuration writes are taken at
// any time. A trace read reads the trace RAM; a list entry read reads the
// list slot and then the trace it names, or returns zero when the position
// is out of range. A set rewrites an active entry's trace or appends a new
// entry when the list has room; a clear zeroes the trace and, if the entry
// is listed, moves the last list entry into its slot. Decay walks the list,
// reading each slot and then the trace it names through the one read port
// of each RAM, and drops entries that decay to zero or below the threshold.
// When a set finds the list full, the threshold is raised and entries below
// it are dropped, repeated until an entry leaves or the threshold is all
// ones. The result waits in the output register while the receiver stalls,
// and the next request can be accepted from the cycle after it is loaded.
// Writing the configuration register loads the live threshold directly.
module sparse_eligibility_trace_store_unit import setsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VAL_W-1:0]  i_cfg_wdata,
    setsu_req_if.sink         i_req,
    setsu_rsp_if.source       o_rsp
);
    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_RTT     = 4'd3;
    localparam logic [3:0] S_RAL     = 4'd4;
    localparam logic [3:0] S_CLRCHK  = 4'd5;
    localparam logic [3:0] S_SETCHK  = 4'd6;
    localparam logic [3:0] S_FULL    = 4'd7;
    localparam logic [3:0] S_RAISE   = 4'd8;
    localparam logic [3:0] S_SWP     = 4'd9;
    localparam logic [3:0] S_SWA     = 4'd10;
    localparam logic [3:0] S_SWT     = 4'd11;
    localparam logic [3:0] S_DEC     = 4'd12;
    localparam logic [3:0] S_DRA     = 4'd13;
    localparam logic [3:0] S_DRB     = 4'd14;
    localparam logic [3:0] S_DRC     = 4'd15;

    // Memory ports.
    logic             tt_we;
    logic [IDX_W-1:0] tt_waddr, tt_raddr;
    logic [VAL_W-1:0] tt_wdata, tt_rd;
    logic             al_we;
    logic [POS_W-1:0] al_waddr, al_raddr;
    logic [IDX_W-1:0] al_wdata, al_rd;
    logic             pm_we;
    logic [IDX_W-1:0] pm_waddr;
    logic [POS_W-1:0] pm_wdata, pm_rd;

    // Control state.
    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_thr, n_thr;
    logic             r_ovalid, n_ovalid;

    // Working registers of the current transaction.
    logic [OP_W-1:0]  r_op, n_op;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_rate, n_rate;
    logic [VAL_W-1:0] r_tr, n_tr;
    logic [IDX_W-1:0] r_ent, n_ent;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_dpos, n_dpos;
    logic [31:0]      r_prod, n_prod;
    logic             r_sweep, n_sweep;
    logic             r_dec, n_dec;
    logic [VAL_W-1:0] r_o_tr, n_o_tr;
    logic [IDX_W-1:0] r_o_ent, n_o_ent;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic [VAL_W-1:0] r_o_thr, n_o_thr;

    logic             accept;
    logic [CNT_W-1:0] pos_m1, cnt_m1;
    logic [16:0]      step, thr_sum;
    logic [VAL_W-1:0] decayed;

    setsu_ram #(.DEPTH(NUM_TRACES), .WIDTH(VAL_W)) u_trace_ram (
        .i_clk(i_clk), .i_we(tt_we), .i_waddr(tt_waddr), .i_wdata(tt_wdata),
        .i_raddr(tt_raddr), .o_rdata(tt_rd)
    );
    setsu_ram #(.DEPTH(MAX_ACTIVE), .WIDTH(IDX_W)) u_list_ram (
        .i_clk(i_clk), .i_we(al_we), .i_waddr(al_waddr), .i_wdata(al_wdata),
        .i_raddr(al_raddr), .o_rdata(al_rd)
    );
    setsu_ram #(.DEPTH(NUM_TRACES), .WIDTH(POS_W)) u_pos_ram (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(r_idx), .o_rdata(pm_rd)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.trace_out     = r_o_tr;
    assign o_rsp.entry_out     = r_o_ent;
    assign o_rsp.active_count  = r_o_cnt;
    assign o_rsp.threshold_out = r_o_thr;

    assign pos_m1  = r_pos - 9'd1;
    assign cnt_m1  = r_count - 9'd1;
    assign decayed = r_prod[31:16];

    // The raise step is max(1, floor(thr / 10)); the sum saturates at all ones.
    always_comb begin
        step = 17'(r_prod[31:RECIP_SHIFT]);
        if (step == 17'd0) begin
            step = 17'd1;
        end
        thr_sum = 17'(r_thr) + step;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_count  = r_count;
        n_thr    = r_thr;
        n_ovalid = r_ovalid;
        n_op     = r_op;
        n_idx    = r_idx;
        n_val    = r_val;
        n_rate   = r_rate;
        n_tr     = r_tr;
        n_ent    = r_ent;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_dpos   = r_dpos;
        n_prod   = r_prod;
        n_sweep  = r_sweep;
        n_dec    = r_dec;
        n_o_tr   = r_o_tr;
        n_o_ent  = r_o_ent;
        n_o_cnt  = r_o_cnt;
        n_o_thr  = r_o_thr;

        tt_we    = 1'b0;
        tt_waddr = r_idx;
        tt_wdata = '0;
        tt_raddr = r_idx;
        al_we    = 1'b0;
        al_waddr = r_dpos;
        al_wdata = al_rd;
        al_raddr = r_dpos;
        pm_we    = 1'b0;
        pm_waddr = al_rd;
        pm_wdata = r_dpos;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                tt_we    = 1'b1;
                tt_waddr = r_clr;
                n_clr    = r_clr + 10'd1;
                if (r_clr == IDX_W'(NUM_TRACES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.operation;
                    n_idx   = i_req.trace_index;
                    n_val   = i_req.trace_value;
                    n_rate  = i_req.decay_rate;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_tr  = '0;
                n_ent = '0;
                case (r_op)
                    OP_READ_TRACE: n_state = S_RTT;
                    OP_READ_ENTRY: begin
                        if (r_idx < {1'b0, r_count}) begin
                            al_raddr = r_idx[POS_W-1:0];
                            n_state  = S_RAL;
                        end else begin
                            n_state = S_RTT;
                            n_tr    = '0;
                        end
                    end
                    OP_CLEAR: n_state = S_CLRCHK;
                    OP_SET: begin
                        n_state = (r_val == '0) ? S_CLRCHK : S_SETCHK;
                    end
                    OP_DECAY: begin
                        n_pos   = r_count;
                        n_dec   = 1'b1;
                        n_state = S_SWP;
                    end
                    default: n_state = S_RTT;
                endcase
            end
            S_RTT: begin
                // Finish: load the output register once it is free.
                if (r_op == OP_READ_TRACE || (r_op == OP_READ_ENTRY &&
                        r_idx < {1'b0, r_count})) begin
                    n_tr = tt_rd;
                end
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_o_tr   = (r_op == OP_READ_TRACE || (r_op == OP_READ_ENTRY &&
                                r_idx < {1'b0, r_count})) ? tt_rd : r_tr;
                    n_o_ent  = r_ent;
                    n_o_cnt  = r_count;
                    n_o_thr  = r_thr;
                    n_state  = S_IDLE;
                end
                tt_raddr = (r_op == OP_READ_ENTRY) ? r_ent : r_idx;
            end
            S_RAL: begin
                n_ent    = al_rd;
                tt_raddr = al_rd;
                n_state  = S_RTT;
            end
            S_CLRCHK: begin
                n_state = S_RTT;
                n_op    = OP_CLEAR;
                if (tt_rd != '0) begin
                    if ({1'b0, pm_rd} < r_count) begin
                        n_dpos  = pm_rd;
                        n_sweep = 1'b0;
                        n_state = S_DRA;
                    end else begin
                        tt_we = 1'b1;
                    end
                end
            end
            S_SETCHK: begin
                if (tt_rd != '0) begin
                    tt_we    = 1'b1;
                    tt_wdata = r_val;
                    n_state  = S_RTT;
                end else begin
                    n_dec   = 1'b0;
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                if (r_count >= CNT_W'(MAX_ACTIVE)) begin
                    if (r_thr == '1) begin
                        n_state = S_RTT;
                    end else begin
                        n_prod  = 32'(r_thr) * 32'(RECIP_TEN);
                        n_state = S_RAISE;
                    end
                end else begin
                    tt_we    = 1'b1;
                    tt_wdata = r_val;
                    al_we    = 1'b1;
                    al_waddr = r_count[POS_W-1:0];
                    al_wdata = r_idx;
                    pm_we    = 1'b1;
                    pm_waddr = r_idx;
                    pm_wdata = r_count[POS_W-1:0];
                    n_count  = r_count + 9'd1;
                    n_state  = S_RTT;
                end
            end
            S_RAISE: begin
                n_thr   = thr_sum[16] ? '1 : thr_sum[VAL_W-1:0];
                n_pos   = r_count;
                n_state = S_SWP;
            end
            S_SWP: begin
                if (r_pos == '0) begin
                    n_state = r_dec ? S_RTT : S_FULL;
                end else begin
                    al_raddr = pos_m1[POS_W-1:0];
                    n_state  = S_SWA;
                end
            end
            S_SWA: begin
                n_cur    = al_rd;
                tt_raddr = al_rd;
                n_state  = S_SWT;
            end
            S_SWT: begin
                if (r_dec) begin
                    n_prod  = 32'(tt_rd) * 32'(r_rate);
                    n_state = S_DEC;
                end else if (tt_rd < r_thr) begin
                    n_dpos  = pos_m1[POS_W-1:0];
                    n_pos   = pos_m1;
                    n_sweep = 1'b1;
                    n_state = S_DRA;
                end else begin
                    n_pos   = pos_m1;
                    n_state = S_SWP;
                end
            end
            S_DEC: begin
                tt_we    = 1'b1;
                tt_waddr = r_cur;
                tt_wdata = decayed;
                n_pos    = pos_m1;
                if (decayed == '0 || decayed < r_thr) begin
                    n_dpos  = pos_m1[POS_W-1:0];
                    n_sweep = 1'b1;
                    n_state = S_DRA;
                end else begin
                    n_state = S_SWP;
                end
            end
            S_DRA: begin
                n_state = S_DRB;
            end
            S_DRB: begin
                // Zero the dropped trace and fetch the last list slot.
                tt_we    = 1'b1;
                tt_waddr = al_rd;
                n_count  = cnt_m1;
                al_raddr = cnt_m1[POS_W-1:0];
                n_state  = S_DRC;
            end
            S_DRC: begin
                al_we   = 1'b1;
                pm_we   = 1'b1;
                n_state = r_sweep ? S_SWP : S_RTT;
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            n_thr = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_count  <= '0;
            r_thr    <= THR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_thr    <= n_thr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_rate  <= n_rate;
        r_tr    <= n_tr;
        r_ent   <= n_ent;
        r_cur   <= n_cur;
        r_pos   <= n_pos;
        r_dpos  <= n_dpos;
        r_prod  <= n_prod;
        r_sweep <= n_sweep;
        r_dec   <= n_dec;
        r_o_tr  <= n_o_tr;
        r_o_ent <= n_o_ent;
        r_o_cnt <= n_o_cnt;
        r_o_thr <= n_o_thr;
    end

`ifndef SYNTHESIS
    // The list never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ACTIVE))
        else $error("active count exceeds list depth");

    // An accepted transaction always moves the sequencer to dispatch.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

    // The live threshold only rises, except on a configuration write.
    a_thr_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg_we) |=> (r_thr >= $past(r_thr)))
        else $error("live threshold decreased");
`endif
endmodule
